@@ sv/rfr_pkg.sv @@
// Shared types and constants for the radio frame responder.
package rfr_pkg;

  localparam int unsigned NumCfgRegs = 6;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned ErrW       = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ECHO_HDR   = 3'd0,
    CFG_PARAM_HDR  = 3'd1,
    CFG_REPLY_HDR  = 3'd2,
    CFG_BEACON_SUB = 3'd3,
    CFG_PING_SUB   = 3'd4,
    CFG_NODE_ID    = 3'd5
  } cfg_idx_e;

  localparam logic [ByteW-1:0] EchoHdrRst   = 8'd1;
  localparam logic [ByteW-1:0] ParamHdrRst  = 8'd2;
  localparam logic [ByteW-1:0] ReplyHdrRst  = 8'd3;
  localparam logic [ByteW-1:0] BeaconSubRst = 8'd1;
  localparam logic [ByteW-1:0] PingSubRst   = 8'd2;
  localparam logic [ByteW-1:0] NodeIdRst    = 8'd1;

  // Error flag bit positions
  localparam int unsigned ErrHeaderBit = 0;
  localparam int unsigned ErrNodeBit   = 1;
  localparam int unsigned ErrSubcmdBit = 2;

  localparam logic [ByteW-1:0] GapMax = 8'd255;

  typedef struct packed {
    logic [ByteW-1:0] echo_header_code;
    logic [ByteW-1:0] param_header_code;
    logic [ByteW-1:0] reply_header_code;
    logic [ByteW-1:0] beacon_subcmd_code;
    logic [ByteW-1:0] ping_subcmd_code;
    logic [ByteW-1:0] own_node_id;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] frame_header;
    logic [ByteW-1:0] master_id;
    logic [ByteW-1:0] target_id;
    logic [ByteW-1:0] sub_command;
    logic [ByteW-1:0] time_seconds;
    logic [ByteW-1:0] sequence_number;
    logic [ByteW-1:0] tick_count_in;
    logic [ByteW-1:0] link_rssi;
    logic [ByteW-1:0] link_snr;
  } frame_t;

  typedef struct packed {
    logic [ErrW-1:0]  error_flags;
    logic             reply_valid;
    logic [ByteW-1:0] reply_header;
    logic [ByteW-1:0] reply_master_id;
    logic [ByteW-1:0] reply_rssi;
    logic [ByteW-1:0] reply_snr;
    logic [ByteW-1:0] reply_sequence;
    logic [ByteW-1:0] seconds_now;
    logic [ByteW-1:0] ticks_now;
    logic [ByteW-1:0] lost_frames;
  } result_t;

endpackage

@@ sv/rfr_cfg_regs.sv @@
// Configuration register file for the frame responder.
module rfr_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [rfr_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  logic [rfr_pkg::ByteW-1:0]    wr_data_i,
  output rfr_pkg::cfg_t                cfg_o
);
  import rfr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        CFG_ECHO_HDR:   cfg_d.echo_header_code   = wr_data_i;
        CFG_PARAM_HDR:  cfg_d.param_header_code  = wr_data_i;
        CFG_REPLY_HDR:  cfg_d.reply_header_code  = wr_data_i;
        CFG_BEACON_SUB: cfg_d.beacon_subcmd_code = wr_data_i;
        CFG_PING_SUB:   cfg_d.ping_subcmd_code   = wr_data_i;
        CFG_NODE_ID:    cfg_d.own_node_id        = wr_data_i;
        default:        cfg_d = cfg_q; // drop writes past the last register
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.echo_header_code   <= EchoHdrRst;
      cfg_q.param_header_code  <= ParamHdrRst;
      cfg_q.reply_header_code  <= ReplyHdrRst;
      cfg_q.beacon_subcmd_code <= BeaconSubRst;
      cfg_q.ping_subcmd_code   <= PingSubRst;
      cfg_q.own_node_id        <= NodeIdRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/rfr_core.sv @@
// Frame decode, time and sequence state, and result formation.
module rfr_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  rfr_pkg::cfg_t     cfg_i,
  input  rfr_pkg::frame_t   frame_i,
  output rfr_pkg::result_t  result_o
);
  import rfr_pkg::*;

  logic [ByteW-1:0] seconds_q, seconds_d;
  logic [ByteW-1:0] ticks_q, ticks_d;
  logic [ByteW-1:0] exp_seq_q, exp_seq_d;
  logic [ByteW-1:0] gap_q, gap_d;

  logic is_echo, is_param, node_ok, beacon, ping;

  always_comb begin
    // echo wins when both header codes are equal
    is_echo  = (frame_i.frame_header == cfg_i.echo_header_code);
    is_param = !is_echo && (frame_i.frame_header == cfg_i.param_header_code);
    node_ok  = (frame_i.target_id == cfg_i.own_node_id);
    beacon   = is_echo && (frame_i.sub_command == cfg_i.beacon_subcmd_code);
    ping     = is_param && node_ok && (frame_i.sub_command == cfg_i.ping_subcmd_code);

    seconds_d = beacon ? frame_i.time_seconds  : seconds_q;
    ticks_d   = beacon ? frame_i.tick_count_in : ticks_q;
    exp_seq_d = ping ? frame_i.sequence_number + 8'd1 : exp_seq_q;
    gap_d     = gap_q;
    if (ping && (exp_seq_q != frame_i.sequence_number) && (gap_q != GapMax)) begin
      gap_d = gap_q + 8'd1;
    end

    result_o = '0;
    result_o.error_flags[ErrHeaderBit] = !is_echo && !is_param;
    result_o.error_flags[ErrNodeBit]   = is_param && !node_ok;
    result_o.error_flags[ErrSubcmdBit] = (is_echo && !beacon)
                                       || (is_param && node_ok && !ping);
    result_o.reply_valid = ping;
    if (ping) begin
      result_o.reply_header    = cfg_i.reply_header_code;
      result_o.reply_master_id = frame_i.master_id;
      result_o.reply_rssi      = frame_i.link_rssi;
      result_o.reply_snr       = frame_i.link_snr;
      result_o.reply_sequence  = frame_i.sequence_number;
    end
    result_o.seconds_now = seconds_d;
    result_o.ticks_now   = ticks_d;
    result_o.lost_frames = gap_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seconds_q <= '0;
      ticks_q   <= '0;
      exp_seq_q <= '0;
      gap_q     <= '0;
    end else if (fire_i) begin
      seconds_q <= seconds_d;
      ticks_q   <= ticks_d;
      exp_seq_q <= exp_seq_d;
      gap_q     <= gap_d;
    end
  end

endmodule

@@ sv/radio_frame_responder_top.sv @@
// Top level of the radio frame responder: handshake, input and result registers.
//
// Slave stream: one transaction carries the decoded fields of one received
// frame plus link RSSI and SNR. Master stream: one result per frame with the
// error flags, the reply frame fields (zero when no reply is due) and the
// seconds, tick and lost-frame counters after the frame.
// Configuration channel: cfg_valid_i/cfg_ready_o with a register index and
// 8-bit data; write only while no frame is in flight. Indexes past the last
// register are ignored.
// Result path: an accepted frame is captured in the input register, which feeds
// the decode; the result register captures the decode output when the held
// frame advances. Throughput: one frame per cycle while the receiver keeps
// m_axis_tready high; the decode and counter update is a single compare-and-update
// step between the input register and the result register.
// Reset: the counters clear, the code registers load their defaults and both
// pipeline registers empty. When the receiver stalls, the result register
// holds, the input register fills behind it, and then s_axis_tready drops.
module radio_frame_responder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // tdata: master_id, target_id, sub_command, time_seconds, sequence_number,
  //        tick_count_in, link_rssi, link_snr (8 bits each, lowest first)
  input  logic [63:0]                  s_axis_tdata,
  // tuser: frame_header[7:0]
  input  logic [7:0]                   s_axis_tuser,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: reply_header, reply_master_id, reply_rssi, reply_snr,
  //        reply_sequence, seconds_now, ticks_now, lost_frames (8 bits each)
  output logic [63:0]                  m_axis_tdata,
  // tuser: error_flags[2:0], reply_valid[3]
  output logic [3:0]                   m_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rfr_pkg::ByteW-1:0]    cfg_data_i
);
  import rfr_pkg::*;

  cfg_t    cfg;
  frame_t  in_q, in_d;
  logic    in_valid_q;
  result_t res;
  result_t out_q;
  logic    out_valid_q;
  logic    advance, in_take;

  assign cfg_ready_o = 1'b1;

  rfr_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // advance the held frame when the result register is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_d.frame_header    = s_axis_tuser;
    in_d.master_id       = s_axis_tdata[7:0];
    in_d.target_id       = s_axis_tdata[15:8];
    in_d.sub_command     = s_axis_tdata[23:16];
    in_d.time_seconds    = s_axis_tdata[31:24];
    in_d.sequence_number = s_axis_tdata[39:32];
    in_d.tick_count_in   = s_axis_tdata[47:40];
    in_d.link_rssi       = s_axis_tdata[55:48];
    in_d.link_snr        = s_axis_tdata[63:56];
  end

  rfr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .cfg_i    (cfg),
    .frame_i  (in_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_d;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = {out_q.reply_valid, out_q.error_flags};
  assign m_axis_tdata  = {out_q.lost_frames, out_q.ticks_now, out_q.seconds_now,
                          out_q.reply_sequence, out_q.reply_snr, out_q.reply_rssi,
                          out_q.reply_master_id, out_q.reply_header};

endmodule

@@ sim/tb_radio_frame_responder_top.sv @@
// Self-checking stream testbench for the radio frame responder top level.
`timescale 1ns / 100ps

module tb_radio_frame_responder_top;
  import rfr_pkg::*;

  localparam logic [CfgIdxW-1:0] IdxPastEnd = CfgIdxW'(NumCfgRegs);
  localparam logic [CfgIdxW-1:0] IdxTop     = '1;
  localparam int unsigned        MaxReports = 10;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic [63:0]         s_axis_tdata;
  logic [7:0]          s_axis_tuser;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [63:0]         m_axis_tdata;
  logic [3:0]          m_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [ByteW-1:0]    cfg_data_i;

  radio_frame_responder_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the code registers and the frame counters
  cfg_t             codes;
  logic [ByteW-1:0] seconds_q;
  logic [ByteW-1:0] ticks_q;
  logic [ByteW-1:0] last_master_q;
  logic [ByteW-1:0] last_seq_q;
  logic [ByteW-1:0] next_seq_q;
  logic [ByteW-1:0] lost_q;

  result_t     predicted_responses[$];
  int unsigned mismatch_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_cycles = 0;

  function automatic result_t compute_response(frame_t f);
    result_t r;
    r = '0;
    if (f.frame_header == codes.echo_header_code) begin
      if (f.sub_command == codes.beacon_subcmd_code) begin
        ticks_q   = f.tick_count_in;
        seconds_q = f.time_seconds;
      end else begin
        r.error_flags[ErrSubcmdBit] = 1'b1;
      end
    end else if (f.frame_header == codes.param_header_code) begin
      if (f.target_id != codes.own_node_id) begin
        r.error_flags[ErrNodeBit] = 1'b1;
      end else if (f.sub_command == codes.ping_subcmd_code) begin
        last_master_q = f.master_id;
        last_seq_q    = f.sequence_number;
        if (next_seq_q != f.sequence_number && lost_q != GapMax) lost_q = lost_q + 8'd1;
        next_seq_q = f.sequence_number + 8'd1;
        r.reply_valid     = 1'b1;
        r.reply_header    = codes.reply_header_code;
        r.reply_master_id = last_master_q;
        r.reply_rssi      = f.link_rssi;
        r.reply_snr       = f.link_snr;
        r.reply_sequence  = last_seq_q;
      end else begin
        r.error_flags[ErrSubcmdBit] = 1'b1;
      end
    end else begin
      r.error_flags[ErrHeaderBit] = 1'b1;
    end
    r.seconds_now = seconds_q;
    r.ticks_now   = ticks_q;
    r.lost_frames = lost_q;
    return r;
  endfunction

  // Caller must follow with another send or with drain_responses.
  task automatic send_frame(frame_t f);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {f.link_snr, f.link_rssi, f.tick_count_in, f.sequence_number,
                      f.time_seconds, f.sub_command, f.target_id, f.master_id};
    s_axis_tuser  <= f.frame_header;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted_responses.push_back(compute_response(f));
  endtask

  task automatic drain_responses();
    s_axis_tvalid <= 1'b0;
    while (predicted_responses.size() != 0) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after the last write.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ECHO_HDR:   codes.echo_header_code   = data;
      CFG_PARAM_HDR:  codes.param_header_code  = data;
      CFG_REPLY_HDR:  codes.reply_header_code  = data;
      CFG_BEACON_SUB: codes.beacon_subcmd_code = data;
      CFG_PING_SUB:   codes.ping_subcmd_code   = data;
      CFG_NODE_ID:    codes.own_node_id        = data;
      default: ;
    endcase
  endtask

  task automatic load_codes(cfg_t c);
    write_reg(CFG_ECHO_HDR, c.echo_header_code);
    write_reg(CFG_PARAM_HDR, c.param_header_code);
    write_reg(CFG_REPLY_HDR, c.reply_header_code);
    write_reg(CFG_BEACON_SUB, c.beacon_subcmd_code);
    write_reg(CFG_PING_SUB, c.ping_subcmd_code);
    write_reg(CFG_NODE_ID, c.own_node_id);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic frame_t build_frame(logic [7:0] hdr, logic [7:0] tid, logic [7:0] sub,
                                         logic [7:0] seq);
    frame_t      f;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    f = raw[71:0];
    f.frame_header    = hdr;
    f.target_id       = tid;
    f.sub_command     = sub;
    f.sequence_number = seq;
    return f;
  endfunction

  function automatic frame_t random_frame();
    frame_t      f;
    int unsigned pick;
    f = build_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 35) begin
      f.frame_header = codes.echo_header_code;
      f.sub_command  = codes.beacon_subcmd_code;
    end else if (pick < 80) begin
      f.frame_header = codes.param_header_code;
      f.target_id    = codes.own_node_id;
      f.sub_command  = codes.ping_subcmd_code;
      if ($urandom_range(99) < 85) f.sequence_number = next_seq_q;
    end else if (pick < 87) begin
      f.frame_header = codes.param_header_code;
      f.sub_command  = codes.ping_subcmd_code;
    end else if (pick < 94) begin
      f.frame_header = codes.param_header_code;
      f.target_id    = codes.own_node_id;
    end else if (pick < 97) begin
      f.frame_header = codes.echo_header_code;
    end
    return f;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      if (mismatch_count < MaxReports)
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_responses
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.reply_header    = m_axis_tdata[7:0];
      got.reply_master_id = m_axis_tdata[15:8];
      got.reply_rssi      = m_axis_tdata[23:16];
      got.reply_snr       = m_axis_tdata[31:24];
      got.reply_sequence  = m_axis_tdata[39:32];
      got.seconds_now     = m_axis_tdata[47:40];
      got.ticks_now       = m_axis_tdata[55:48];
      got.lost_frames     = m_axis_tdata[63:56];
      got.error_flags     = m_axis_tuser[2:0];
      got.reply_valid     = m_axis_tuser[3];
      if (predicted_responses.size() == 0) begin
        if (mismatch_count < MaxReports)
          $display("%0t: response with none outstanding", $realtime);
        mismatch_count++;
      end else begin
        want = predicted_responses.pop_front();
        check_field("error_flags", 8'(want.error_flags), 8'(got.error_flags));
        check_field("reply_valid", 8'(want.reply_valid), 8'(got.reply_valid));
        check_field("reply_header", want.reply_header, got.reply_header);
        check_field("reply_master_id", want.reply_master_id, got.reply_master_id);
        check_field("reply_rssi", want.reply_rssi, got.reply_rssi);
        check_field("reply_snr", want.reply_snr, got.reply_snr);
        check_field("reply_sequence", want.reply_sequence, got.reply_sequence);
        check_field("seconds_now", want.seconds_now, got.seconds_now);
        check_field("ticks_now", want.ticks_now, got.ticks_now);
        check_field("lost_frames", want.lost_frames, got.lost_frames);
      end
    end
  end

  // Receiver: random backpressure, or a counted hold-off when requested
  initial begin : receiver
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic test_default_codes();
    // beacon loads counters
    send_frame(build_frame(EchoHdrRst, 8'd9, BeaconSubRst, 8'd0));
    send_frame(build_frame(EchoHdrRst, NodeIdRst, BeaconSubRst, 8'hFF));
    // first ping, in order
    send_frame(build_frame(ParamHdrRst, NodeIdRst, PingSubRst, 8'd0));
    send_frame(build_frame(ParamHdrRst, NodeIdRst, PingSubRst, 8'd1));
    // repeat counts as a gap
    send_frame(build_frame(ParamHdrRst, NodeIdRst, PingSubRst, 8'd1));
    send_frame(build_frame(ParamHdrRst, NodeIdRst, PingSubRst, 8'hFF));
    // in order across wrap
    send_frame(build_frame(ParamHdrRst, NodeIdRst, PingSubRst, 8'd0));
    // other node
    send_frame(build_frame(ParamHdrRst, 8'hFF, PingSubRst, 8'd1));
    // other node, bad subcommand
    send_frame(build_frame(ParamHdrRst, 8'd0, 8'hFF, 8'd1));
    // unknown subcommand
    send_frame(build_frame(ParamHdrRst, NodeIdRst, 8'hFF, 8'd1));
    // echo, not a beacon
    send_frame(build_frame(EchoHdrRst, NodeIdRst, PingSubRst, 8'd1));
    // unknown headers
    send_frame(build_frame(8'd0, NodeIdRst, BeaconSubRst, 8'd1));
    send_frame(build_frame(8'hFF, NodeIdRst, PingSubRst, 8'd1));
    send_frame(build_frame(8'd3, NodeIdRst, PingSubRst, 8'd1));
    drain_responses();
  endtask

  task automatic test_shared_header();
    cfg_t c;
    c = '{echo_header_code: 8'h80, param_header_code: 8'h80, reply_header_code: 8'hFF,
          beacon_subcmd_code: 8'h00, ping_subcmd_code: 8'hFF, own_node_id: 8'h00};
    load_codes(c);
    // Shared header resolves to echo, so a ping subcommand is rejected there.
    send_frame(build_frame(8'h80, 8'h00, 8'h00, 8'd5));
    send_frame(build_frame(8'h80, 8'h00, 8'hFF, 8'd5));
    send_frame(build_frame(8'h80, 8'h77, 8'h00, 8'd5));
    drain_responses();
    c.echo_header_code = 8'h00;
    load_codes(c);
    send_frame(build_frame(8'h80, 8'h00, 8'hFF, next_seq_q));
    send_frame(build_frame(8'h80, 8'hFF, 8'hFF, 8'd7));
    drain_responses();
  endtask

  task automatic test_unused_index();
    write_reg(IdxPastEnd, 8'h5A);
    write_reg(IdxTop, 8'hA5);
    cfg_valid_i <= 1'b0;
    send_frame(build_frame(codes.param_header_code, codes.own_node_id,
                           codes.ping_subcmd_code, 8'd3));
    send_frame(build_frame(codes.echo_header_code, 8'd0, codes.beacon_subcmd_code, 8'd0));
    drain_responses();
  endtask

  task automatic test_random_traffic(int unsigned n, int unsigned tx, int unsigned rx,
                                     cfg_t c);
    load_codes(c);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    repeat (n) send_frame(random_frame());
    drain_responses();
  endtask

  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_cycles  = 150;
    repeat (30)
      send_frame(build_frame(codes.param_header_code, codes.own_node_id,
                             codes.ping_subcmd_code, next_seq_q));
    drain_responses();
  endtask

  task automatic test_lost_saturation();
    tx_idle_pct  = 10;
    rx_stall_pct = 10;
    // Skip ahead every time so each ping counts as lost.
    repeat (270)
      send_frame(build_frame(codes.param_header_code, codes.own_node_id,
                             codes.ping_subcmd_code,
                             next_seq_q + 8'd1 + 8'($urandom_range(254))));
    drain_responses();
  endtask

  initial begin : stimulus
    cfg_t c;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tvalid = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    codes = '{echo_header_code: EchoHdrRst, param_header_code: ParamHdrRst,
              reply_header_code: ReplyHdrRst, beacon_subcmd_code: BeaconSubRst,
              ping_subcmd_code: PingSubRst, own_node_id: NodeIdRst};
    {seconds_q, ticks_q, last_master_q, last_seq_q, next_seq_q, lost_q} = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_codes();
    test_shared_header();
    test_unused_index();

    c = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
    test_random_traffic(250, 0, 0, c);
    c = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
    test_random_traffic(250, 55, 0, c);
    c = cfg_t'(48'({$urandom, $urandom}));
    test_random_traffic(250, 0, 55, c);
    test_backpressure();
    c = cfg_t'(48'({$urandom, $urandom}));
    test_random_traffic(250, 10, 10, c);
    test_lost_saturation();

    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0 && predicted_responses.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
